[rtl/pfic_pkg.sv]
// Shared types and constants for the playout frame interval control block.
// Field widths, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfic_pkg;

  // payload field widths
  localparam int unsigned T_W   = 16;  // target time, ms
  localparam int unsigned F_W   = 12;  // buffered frames
  localparam int unsigned L_W   = 11;  // last interval, ms
  localparam int unsigned OUT_W = 11;  // new interval, ms

  // configuration register widths
  localparam int unsigned FPS_W = 7;
  localparam int unsigned WIN_W = 8;
  localparam int unsigned DIV_W = 16;
  localparam int unsigned CAP_W = 8;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;

  // configuration reset values
  localparam logic [FPS_W-1:0] FPS_RST = FPS_W'(10);
  localparam logic [WIN_W-1:0] WIN_RST = WIN_W'(2);
  localparam logic [DIV_W-1:0] DIV_RST = DIV_W'(1000);
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(10);

  typedef enum logic [CFG_AW-1:0] {
    CFG_FPS     = 2'd0,
    CFG_WINDOW  = 2'd1,
    CFG_DIVISOR = 2'd2,
    CFG_CAP     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [FPS_W-1:0] fps;
    logic [WIN_W-1:0] window;
    logic [DIV_W-1:0] divisor;
    logic [CAP_W-1:0] cap;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/pfic_core.sv]
// Pipelined datapath of the playout frame interval control block.
// Window test, band select, step bound divider and final clamp.
// Depends on pfic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfic_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire  pfic_pkg::cfg_t       cfg_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [pfic_pkg::T_W-1:0]   target_time_ms_i,
  input  wire  [pfic_pkg::F_W-1:0]   frames_buffered_i,
  input  wire  [pfic_pkg::L_W-1:0]   last_interval_ms_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [pfic_pkg::OUT_W-1:0] interval_ms_o
);
  import pfic_pkg::*;

  localparam int unsigned Q_W    = 9;            // step bound quotient bits (cap is at most 510)
  localparam int unsigned NUM_W  = 19;           // 5*T + divisor - 1
  localparam int unsigned D_W    = 19;           // buffered time and band bounds
  localparam int unsigned NRM_W  = T_W + FPS_W;  // T * fps
  localparam int unsigned F1K_W  = 22;           // F * 1000
  localparam int unsigned W1K_W  = 18;           // window * 1000
  localparam int unsigned CMP_W  = 24;           // window upper bound
  localparam int unsigned DSH_W  = DIV_W + Q_W;  // shifted divisor
  localparam int unsigned BASE_W = 10;           // 1000 / fps
  localparam int unsigned R_W    = 12;           // base plus band offset, signed
  localparam int unsigned DL_W   = 7;            // band offset, signed
  localparam int unsigned X_W    = 13;           // final arithmetic, signed

  localparam int unsigned ST_S1  = 0;
  localparam int unsigned ST_S2  = 1;
  localparam int unsigned ST_DV0 = 2;
  localparam int unsigned NST    = Q_W + 4;
  localparam int unsigned ST_OUT = NST - 1;

  localparam logic signed [DL_W-1:0] DL_P50 = DL_W'(50);
  localparam logic signed [DL_W-1:0] DL_P30 = DL_W'(30);
  localparam logic signed [DL_W-1:0] DL_P5  = DL_W'(5);
  localparam logic signed [DL_W-1:0] DL_M5  = -DL_W'(5);
  localparam logic signed [DL_W-1:0] DL_M10 = -DL_W'(10);
  localparam logic signed [DL_W-1:0] DL_M30 = -DL_W'(30);
  localparam logic signed [DL_W-1:0] DL_M40 = -DL_W'(40);
  localparam logic signed [DL_W-1:0] DL_M50 = -DL_W'(50);

  typedef struct packed {
    logic [L_W-1:0]          l;
    logic                    win;
    logic signed [R_W-1:0]   r0;
    logic                    sat;
    logic [NUM_W-1:0]        rem;
    logic [Q_W-1:0]          q;
  } dv_t;

  // base interval table, one entry per frame rate code
  logic [BASE_W-1:0] base_tbl [2**FPS_W];
  for (genvar g = 0; g < 2**FPS_W; g++) begin : g_base
    localparam int unsigned Val = 1000 / ((g == 0) ? 1 : g);
    assign base_tbl[g] = BASE_W'(Val);
  end

  logic [FPS_W-1:0] fps_eff;
  logic [DIV_W-1:0] div_eff;
  assign fps_eff = (cfg_i.fps == '0) ? FPS_W'(1) : cfg_i.fps;
  assign div_eff = (cfg_i.divisor == '0) ? DIV_W'(1) : cfg_i.divisor;

  // ---------------------------------------------------------------- flow control
  logic [NST-1:0] v_q, v_d, adv;

  always_comb begin
    adv[ST_OUT] = !v_q[ST_OUT] || out_ready_i;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NST; i++) begin
      v_d[i] = adv[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = adv[ST_S1];
  assign out_valid_o = v_q[ST_OUT];

  // ---------------------------------------------------------------- stage 1: capture
  logic [T_W-1:0] t1_q;
  logic [F_W-1:0] f1_q;
  logic [L_W-1:0] l1_q;

  always_ff @(posedge clk_i) begin
    if (adv[ST_S1]) begin
      t1_q <= target_time_ms_i;
      f1_q <= frames_buffered_i;
      l1_q <= last_interval_ms_i;
    end
  end

  // ---------------------------------------------------------------- stage 2: products and bounds
  logic [NRM_W-1:0]  nrm2_q;
  logic [F1K_W-1:0]  f1k2_q;
  logic [W1K_W-1:0]  w1k2_q;
  logic [D_W-1:0]    d2_q;
  logic [NUM_W-1:0]  num2_q;
  logic [BASE_W-1:0] base2_q;
  logic [L_W-1:0]    l2_q;
  logic [D_W-1:0]    b_h_q, b_q3_q, b_tm50_q, b_tm100_q, b_tp100_q;
  logic [D_W-1:0]    b_q5_q, b_q6_q, b_q7_q, b_t2_q;
  logic              tm50_neg_q, tm100_neg_q;

  logic [D_W-1:0] t19;
  assign t19 = D_W'(t1_q);

  always_ff @(posedge clk_i) begin
    if (adv[ST_S2]) begin
      nrm2_q      <= NRM_W'(t1_q) * NRM_W'(fps_eff);
      f1k2_q      <= F1K_W'(f1_q) * F1K_W'(1000);
      w1k2_q      <= W1K_W'(cfg_i.window) * W1K_W'(1000);
      d2_q        <= D_W'(f1_q) * D_W'(100);
      num2_q      <= NUM_W'(20'(t1_q) * 20'd5 + 20'(div_eff) - 20'd1);
      base2_q     <= base_tbl[fps_eff];
      l2_q        <= l1_q;
      b_h_q       <= t19 >> 1;
      b_q3_q      <= (t19 * D_W'(3)) >> 2;
      b_tm50_q    <= t19 - D_W'(50);
      b_tm100_q   <= t19 - D_W'(100);
      tm50_neg_q  <= (t1_q < T_W'(50));
      tm100_neg_q <= (t1_q < T_W'(100));
      b_tp100_q   <= t19 + D_W'(100);
      b_q5_q      <= (t19 * D_W'(5)) >> 2;
      b_q6_q      <= (t19 * D_W'(6)) >> 2;
      b_q7_q      <= (t19 * D_W'(7)) >> 2;
      b_t2_q      <= t19 << 1;
    end
  end

  // ---------------------------------------------------------------- stage 3: window, band, saturation
  logic                   win3;
  logic signed [DL_W-1:0] delta3;
  dv_t                    dv0_d;

  always_comb begin
    win3 = (CMP_W'(f1k2_q) >= CMP_W'(nrm2_q)) &&
           (CMP_W'(f1k2_q) <= CMP_W'(nrm2_q) + CMP_W'(w1k2_q));

    // bands in priority order; a negative edge of the middle bands is open
    if (d2_q <= b_h_q) begin
      delta3 = DL_P50;
    end else if (d2_q <= b_q3_q) begin
      delta3 = DL_P30;
    end else if (tm50_neg_q || d2_q <= b_tm50_q) begin
      delta3 = DL_P5;
    end else if ((tm100_neg_q || d2_q > b_tm100_q) && d2_q <= b_tp100_q) begin
      delta3 = '0;
    end else if (d2_q > b_tp100_q && d2_q <= b_q5_q) begin
      delta3 = DL_M5;
    end else if (d2_q > b_q5_q && d2_q <= b_q6_q) begin
      delta3 = DL_M10;
    end else if (d2_q > b_q6_q && d2_q <= b_q7_q) begin
      delta3 = DL_M30;
    end else if (d2_q > b_q7_q && d2_q <= b_t2_q) begin
      delta3 = DL_M40;
    end else begin
      delta3 = DL_M50;
    end
    if (win3) begin
      delta3 = '0;
    end

    dv0_d.l   = l2_q;
    dv0_d.win = win3;
    dv0_d.r0  = $signed({2'b00, base2_q}) + {{(R_W-DL_W){delta3[DL_W-1]}}, delta3};
    dv0_d.sat = (DSH_W'(num2_q) >= {div_eff, {Q_W{1'b0}}});
    dv0_d.rem = num2_q;
    dv0_d.q   = '0;
  end

  // ---------------------------------------------------------------- divider: one quotient bit per stage
  dv_t dv_q  [Q_W+1];
  dv_t dv_nx [Q_W];

  always_comb begin : p_div
    logic [DSH_W-1:0] dsh;
    dsh = '0;
    for (int j = 0; j < Q_W; j++) begin
      dv_nx[j] = dv_q[j];
      dsh      = DSH_W'(div_eff) << (Q_W - 1 - j);
      if (DSH_W'(dv_q[j].rem) >= dsh) begin
        dv_nx[j].rem            = dv_q[j].rem - NUM_W'(dsh);
        dv_nx[j].q[Q_W - 1 - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_DV0]) begin
      dv_q[0] <= dv0_d;
    end
    for (int j = 0; j < Q_W; j++) begin
      if (adv[ST_DV0 + 1 + j]) begin
        dv_q[j+1] <= dv_nx[j];
      end
    end
  end

  // ---------------------------------------------------------------- final: step bound and clamp
  dv_t                   dvf;
  logic [Q_W-1:0]        step_f, cap2;
  logic signed [X_W-1:0] r13, l13, s13, rr;
  logic [OUT_W-1:0]      res_d, out_q;

  assign dvf = dv_q[Q_W];

  always_comb begin
    cap2   = {cfg_i.cap, 1'b0};
    step_f = dvf.sat ? '1 : dvf.q;
    if (step_f > cap2) begin
      step_f = cap2;
    end
    r13 = $signed({dvf.r0[R_W-1], dvf.r0});
    l13 = $signed({2'b00, dvf.l});
    s13 = $signed({4'b0000, step_f});
    rr  = r13;
    if (!dvf.win) begin
      // limit rise, then drop, to one step from the last interval
      if (rr > l13 && rr - l13 > s13) begin
        rr = l13 + s13;
      end
      if (rr < l13 && l13 - rr > s13) begin
        rr = l13 - s13;
      end
    end
    if (rr < 0) begin
      res_d = '0;
    end else if (rr > $signed(X_W'(2047))) begin
      res_d = '1;
    end else begin
      res_d = rr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      out_q <= res_d;
    end
  end

  assign interval_ms_o = out_q;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

`ifndef ASSERT_OFF
  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (v_q == '1)))
    else $error("input held off while the pipeline has room");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("beat lost or duplicated on entry");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_fire) |=> ($countones(v_q) == $past($countones(v_q)) - 1))
    else $error("beat lost or duplicated on exit");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_OUT-1] && !dvf.sat) |-> (dvf.rem < NUM_W'(div_eff)))
    else $error("step divider remainder not below divisor");

  a_rise_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_OUT-1] && !dvf.win && rr > l13) |-> (rr - l13 <= s13))
    else $error("rise exceeds step bound");
`endif

endmodule

`default_nettype wire

[rtl/playout_frame_interval_control.sv]
// Playout frame interval control: one new playout interval per input beat.
// The datapath is 13 register stages deep: capture, products, band select, the divider
// and the output register. A new item is taken every cycle while results keep draining.
// The step bound divider resolves one quotient bit per stage over nine stages.
// Output stalls back up through the stages; bubbles close up.
// Configuration registers (frame rate, window, step divisor, step cap) are written
// through a plain write port and should only change while no beat is in flight.
// Depends on pfic_pkg and pfic_core.
`timescale 1ns / 1ps
`default_nettype none

module playout_frame_interval_control (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [pfic_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire  [pfic_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [pfic_pkg::T_W-1:0]    target_time_ms_i,
  input  wire  [pfic_pkg::F_W-1:0]    frames_buffered_i,
  input  wire  [pfic_pkg::L_W-1:0]    last_interval_ms_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [pfic_pkg::OUT_W-1:0]  interval_ms_o
);
  import pfic_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fps     <= FPS_RST;
      cfg_q.window  <= WIN_RST;
      cfg_q.divisor <= DIV_RST;
      cfg_q.cap     <= CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FPS:     cfg_q.fps     <= cfg_wdata_i[FPS_W-1:0];
        CFG_WINDOW:  cfg_q.window  <= cfg_wdata_i[WIN_W-1:0];
        CFG_DIVISOR: cfg_q.divisor <= cfg_wdata_i[DIV_W-1:0];
        CFG_CAP:     cfg_q.cap     <= cfg_wdata_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  pfic_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .target_time_ms_i   (target_time_ms_i),
    .frames_buffered_i  (frames_buffered_i),
    .last_interval_ms_i (last_interval_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .interval_ms_o      (interval_ms_o)
  );

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for playout_frame_interval_control: directed table, then random beats.
// Holds its own interval predictor and checks every output beat in order.
// Depends on pfic_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import pfic_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned N_PHASES     = 9;
  localparam int unsigned N_RANDOM     = 70;
  localparam int unsigned N_DIRECTED   = 24;

  typedef struct packed {
    logic [T_W-1:0]   t;
    logic [F_W-1:0]   f;
    logic [L_W-1:0]   l;
    logic             pinned;
    logic [OUT_W-1:0] want;
  } dir_row_t;

  // pinned rows carry an interval worked out by hand for the reset settings
  localparam dir_row_t DIR_TAB [0:N_DIRECTED-1] = '{
    '{16'd0,     12'd0,    11'd0,    1'b1, 11'd100},
    '{16'd1000,  12'd10,   11'd100,  1'b1, 11'd100},
    '{16'd1000,  12'd12,   11'd100,  1'b1, 11'd100},
    '{16'd1000,  12'd13,   11'd100,  1'b1, 11'd95},
    '{16'd1000,  12'd9,    11'd100,  1'b1, 11'd105},
    '{16'd0,     12'd4095, 11'd2047, 1'b1, 11'd2047},
    '{16'd0,     12'd4095, 11'd0,    1'b1, 11'd0},
    '{16'd1000,  12'd0,    11'd100,  1'b1, 11'd105},
    '{16'd100,   12'd0,    11'd50,   1'b1, 11'd51},
    '{16'd65535, 12'd4095, 11'd2047, 1'b0, 11'd0},
    '{16'd65535, 12'd0,    11'd0,    1'b0, 11'd0},
    '{16'd30,    12'd5,    11'd100,  1'b0, 11'd0},
    '{16'd80,    12'd3,    11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd10,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd15,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd25,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd35,   11'd100,  1'b0, 11'd0},
    '{16'd4030,  12'd40,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd45,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd55,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd65,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd75,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd90,   11'd100,  1'b0, 11'd0},
    '{16'd4000,  12'd80,   11'd0,    1'b0, 11'd0}
  };

  // fixed settings per phase; phase 0 runs on reset values, the last ones are drawn at random
  localparam cfg_t PHASE_CFG [0:5] = '{
    '{FPS_RST, WIN_RST, DIV_RST, CAP_RST},
    '{7'd1,    8'd0,    16'd1,     8'd0},
    '{7'd100,  8'd255,  16'd65535, 8'd255},
    '{7'd127,  8'd0,    16'd0,     8'd255},
    '{7'd0,    8'd255,  16'd1,     8'd255},
    '{7'd30,   8'd5,    16'd100,   8'd200}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr_i = '0;
  logic [CFG_DW-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [T_W-1:0]      target_time_ms_i = '0;
  logic [F_W-1:0]      frames_buffered_i = '0;
  logic [L_W-1:0]      last_interval_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OUT_W-1:0]    interval_ms_o;

  // hand-worked interval travelling with the beat, when there is one
  logic                beat_pinned = 1'b0;
  logic [OUT_W-1:0]    beat_want = '0;

  cfg_t                cur_cfg = '{FPS_RST, WIN_RST, DIV_RST, CAP_RST};
  logic [OUT_W-1:0]    interval_q [$];
  int unsigned         err_cnt = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         burst_left = 0;
  bit                  valid_up = 1'b0;

  playout_frame_interval_control uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .target_time_ms_i   (target_time_ms_i),
    .frames_buffered_i  (frames_buffered_i),
    .last_interval_ms_i (last_interval_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .interval_ms_o      (interval_ms_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // lower bound exclusive, upper inclusive; a negative bound does not limit
  function automatic bit in_band(longint d, longint lo, longint hi);
    return ((lo < 0) || (d > lo)) && ((hi < 0) || (d <= hi));
  endfunction

  function automatic logic [OUT_W-1:0] calc_interval(logic [T_W-1:0] tt, logic [F_W-1:0] ff,
                                                     logic [L_W-1:0] ll);
    longint t, f, l, fps, dv, base, nrm, r, stp, cap, d, dl;
    t = tt;
    f = ff;
    l = ll;
    fps = (cur_cfg.fps == 0) ? 1 : cur_cfg.fps;
    dv = (cur_cfg.divisor == 0) ? 1 : cur_cfg.divisor;
    base = 1000 / fps;
    nrm = t * fps;
    if (f * 1000 >= nrm && f * 1000 <= nrm + longint'(cur_cfg.window) * 1000) begin
      r = base;
    end else begin
      stp = (t * 5 + dv - 1) / dv;
      cap = longint'(cur_cfg.cap) * 2;
      if (stp > cap) stp = cap;
      d = f * 100;
      if (d <= t / 4)                            dl = 50;
      else if (in_band(d, t / 4, t / 2))         dl = 50;
      else if (in_band(d, t / 2, t * 3 / 4))     dl = 30;
      else if (in_band(d, t * 3 / 4, t - 50))    dl = 5;
      else if (in_band(d, t - 100, t + 100))     dl = 0;
      else if (in_band(d, t + 100, t * 5 / 4))   dl = -5;
      else if (in_band(d, t * 5 / 4, t * 6 / 4)) dl = -10;
      else if (in_band(d, t * 6 / 4, t * 7 / 4)) dl = -30;
      else if (in_band(d, t * 7 / 4, t * 2))     dl = -40;
      else                                       dl = -50;
      r = base + dl;
      if (r > l && r - l > stp) r = l + stp;
      if (r < l && l - r > stp) r = l - stp;
    end
    if (r < 0) r = 0;
    if (r > 2047) r = 2047;
    return OUT_W'(r);
  endfunction

  // predict on input beats, check on output beats; sampled values are those before the edge
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: run did not complete in time", $time);
      $display("== FAIL ==");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (beat_pinned) interval_q.push_back(beat_want);
        else interval_q.push_back(calc_interval(target_time_ms_i, frames_buffered_i,
                                                last_interval_ms_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (interval_q.size() == 0) begin
          $display("%0t: interval_ms %0d arrived with nothing expected", $time, interval_ms_o);
          err_cnt++;
        end else begin
          if (interval_ms_o !== interval_q[0]) begin
            $display("%0t: interval_ms mismatch, expected %0d, actual %0d",
                     $time, interval_q[0], interval_ms_o);
            err_cnt++;
          end
          void'(interval_q.pop_front());
        end
      end
    end
  end

  // receiver stalls in stretches: always ready, coin toss, mostly stalled, fully stalled
  initial begin
    int unsigned mode, len;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  // present one beat and hold it until taken; then either carry on the burst or pause
  task automatic send_beat(logic [T_W-1:0] t, logic [F_W-1:0] f, logic [L_W-1:0] l,
                           logic pin, logic [OUT_W-1:0] want);
    in_valid_i <= 1'b1;
    valid_up = 1'b1;
    target_time_ms_i <= t;
    frames_buffered_i <= f;
    last_interval_ms_i <= l;
    beat_pinned <= pin;
    beat_want <= want;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
    end
  endtask

  // hold the sender until every expected interval is back, then let the pipe settle
  task automatic wait_drained();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    // let the monitor run first so that a beat taken at the last edge is already queued
    @(posedge clk_i);
    while (interval_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(cfg_t c);
    cfg_idx_e idx;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_addr_i <= idx;
      case (idx)
        CFG_FPS:     cfg_wdata_i <= CFG_DW'(c.fps);
        CFG_WINDOW:  cfg_wdata_i <= CFG_DW'(c.window);
        CFG_DIVISOR: cfg_wdata_i <= CFG_DW'(c.divisor);
        default:     cfg_wdata_i <= CFG_DW'(c.cap);
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // mostly frame counts near the window edges and band edges, some fully random beats
  task automatic make_beat(output logic [T_W-1:0] t, output logic [F_W-1:0] f,
                           output logic [L_W-1:0] l);
    longint fps, base, d, li;
    int unsigned kind;
    fps = (cur_cfg.fps == 0) ? 1 : cur_cfg.fps;
    base = 1000 / fps;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      t = T_W'($urandom);
      f = F_W'($urandom);
      l = L_W'($urandom);
    end else begin
      t = ($urandom_range(0, 3) == 0) ? T_W'($urandom) : T_W'($urandom_range(0, 20000));
      if (kind < 4) begin
        d = longint'(t) * fps / 1000 + longint'($urandom_range(0, cur_cfg.window + 2)) - 1;
      end else begin
        d = (longint'(t) * longint'($urandom_range(0, 18)) / 8
             + longint'($urandom_range(0, 300)) - 150) / 100;
      end
      if (d < 0) d = 0;
      if (d > 4095) d = 4095;
      f = F_W'(d);
      if ($urandom_range(0, 4) == 0) begin
        l = L_W'($urandom);
      end else begin
        li = base + longint'($urandom_range(0, 160)) - 80;
        if (li < 0) li = 0;
        if (li > 2047) li = 2047;
        l = L_W'(li);
      end
    end
  endtask

  initial begin
    cfg_t c;
    logic [T_W-1:0] t;
    logic [F_W-1:0] f;
    logic [L_W-1:0] l;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        if (p < 6) begin
          c = PHASE_CFG[p];
        end else begin
          c.fps = FPS_W'($urandom_range(1, 100));
          c.window = ($urandom_range(0, 3) == 0) ? WIN_W'($urandom) : WIN_W'($urandom_range(0, 8));
          c.divisor = ($urandom_range(0, 1) == 0) ? DIV_W'($urandom_range(1, 2000))
                                                  : DIV_W'($urandom);
          c.cap = CAP_W'($urandom);
        end
        apply_config(c);
      end else begin
        foreach (DIR_TAB[i])
          send_beat(DIR_TAB[i].t, DIR_TAB[i].f, DIR_TAB[i].l, DIR_TAB[i].pinned, DIR_TAB[i].want);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
        // hold off mid-phase once so the block fully empties under load
        if (p == 3 && n == N_RANDOM / 2) wait_drained();
        make_beat(t, f, l);
        send_beat(t, f, l, 1'b0, '0);
      end
    end
    wait_drained();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pfic_pkg.sv
rtl/pfic_core.sv
rtl/playout_frame_interval_control.sv
bench/testbench.sv
